// ----- rtl/core/saw_pkg.sv -----
// shared types and constants for the subarray address walker
`default_nettype none

package saw_pkg;

    localparam int SHAPE_W   = 16;
    localparam int IDX_W     = 64;
    localparam int HALF_W    = 32;
    localparam int PORT_DIMS = 4;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;
    localparam int NDIM_W    = 3;

    localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE_0  = 3'd1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_NO_WALK   = 2'd2
    } status_t;

    typedef struct packed {
        logic [IDX_W-1:0] dst_index;
        logic             last;
        status_t          status;
    } meta_t;

endpackage

`default_nettype wire

// ----- rtl/core/subarray_address_walker.sv -----
// top level of the subarray address walker: config registers and channel wiring
//
// Walks a box inside a row-major array of up to four dimensions, last dimension fastest.
// Config: APB registers num_dims (0x00) and shape_0..shape_3 (0x04..0x10). The user must write them
// only while the block is idle; the block itself does not enforce this. pready is tied high.
// Input channel (in_valid/in_ready): kind 0 begins a box walk from start_* to end_*,
// kind 1 steps to the next element. Every input beat yields exactly one output beat.
// Output channel (out_valid/out_ready): src_index, dst_index, last, status
// (0 ok, 1 bad range, 2 no walk active); addresses are zero on error beats.
// Throughput: one beat per cycle sustained on both channels while out_ready stays high.
// An accepted input beat passes through the queue, a load stage, then a multiply stage and
// an add stage for each further dimension of the index pipeline.
// A two-entry queue sits between the cursor logic and the index pipeline; when the
// receiver stalls the pipeline holds, the queue fills and in_ready drops.
// Reset clears the walk (idle), the cursor state and the pipeline; num_dims and all
// shapes reset to 1.
`default_nettype none

module subarray_address_walker #(
    parameter int MAX_DIMS   = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [saw_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [saw_pkg::DATA_W-1:0]   pwdata,
    output logic [saw_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         kind,
    input  wire logic [15:0]                  start_0,
    input  wire logic [15:0]                  start_1,
    input  wire logic [15:0]                  start_2,
    input  wire logic [15:0]                  start_3,
    input  wire logic [15:0]                  end_0,
    input  wire logic [15:0]                  end_1,
    input  wire logic [15:0]                  end_2,
    input  wire logic [15:0]                  end_3,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [63:0]                       src_index,
    output logic [63:0]                       dst_index,
    output logic                              last,
    output logic [1:0]                        status
);

    localparam int PD   = saw_pkg::PORT_DIMS;
    localparam int DIMS = (MAX_DIMS < PD) ? MAX_DIMS : PD;
    localparam int SW   = saw_pkg::SHAPE_W;
    localparam int RW   = saw_pkg::REG_IDX_W;
    localparam int DW   = saw_pkg::DATA_W;
    localparam int NW   = saw_pkg::NDIM_W;
    localparam int MW   = $bits(saw_pkg::meta_t);
    localparam int QW   = MW + 2 * DIMS * SW;

    logic [NW-1:0]           num_dims_reg;
    logic [DIMS-1:0][SW-1:0] shape_reg;
    logic [RW-1:0]           reg_idx;
    logic                    cfg_wr;

    logic [PD-1:0][SW-1:0]   start_all, end_all;

    logic                    fq_valid, fq_ready;
    logic [DIMS-1:0][SW-1:0] fq_coord, fq_ext;
    saw_pkg::meta_t          fq_meta;
    logic                    qb_valid, qb_ready;
    logic [QW-1:0]           qb_data;
    logic [DIMS-1:0][SW-1:0] qb_coord, qb_ext;
    saw_pkg::meta_t          qb_meta;

    assign pready  = 1'b1;
    assign reg_idx = paddr[saw_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= NW'(1);
            for (int k = 0; k < DIMS; k++)
            begin
                shape_reg[k] <= SW'(1);
            end
        end
        else if (cfg_wr)
        begin
            if (reg_idx == saw_pkg::REG_NUM_DIMS)
            begin
                num_dims_reg <= pwdata[NW-1:0];
            end
            for (int k = 0; k < DIMS; k++)
            begin
                if (reg_idx == saw_pkg::REG_SHAPE_0 + RW'(k))
                begin
                    shape_reg[k] <= pwdata[SW-1:0];
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == saw_pkg::REG_NUM_DIMS)
        begin
            prdata = DW'(num_dims_reg);
        end
        for (int k = 0; k < DIMS; k++)
        begin
            if (reg_idx == saw_pkg::REG_SHAPE_0 + RW'(k))
            begin
                prdata = DW'(shape_reg[k]);
            end
        end
    end

    assign start_all = {start_3, start_2, start_1, start_0};
    assign end_all   = {end_3, end_2, end_1, end_0};

    saw_front #(
        .DIMS       (DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .num_dims (num_dims_reg),
        .shape    (shape_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .start_pt (start_all[DIMS-1:0]),
        .end_pt   (end_all[DIMS-1:0]),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_coord  (fq_coord),
        .q_ext    (fq_ext),
        .q_meta   (fq_meta)
    );

    saw_queue #(
        .W (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  ({fq_meta, fq_coord, fq_ext}),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    assign {qb_meta, qb_coord, qb_ext} = qb_data;

    saw_back #(
        .DIMS (DIMS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_coord   (qb_coord),
        .q_ext     (qb_ext),
        .q_meta    (qb_meta),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .src_index (src_index),
        .dst_index (dst_index),
        .last      (last),
        .status    (status)
    );

endmodule

`default_nettype wire

// ----- rtl/core/saw_front.sv -----
// front end: classifies beats, keeps the box and cursor, issues address jobs
`default_nettype none

module saw_front #(
    parameter int DIMS       = 4,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic [saw_pkg::NDIM_W-1:0]                       num_dims,
    input  wire logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0]            shape,
    input  wire logic                                             in_valid,
    output logic                                                  in_ready,
    input  wire logic                                             kind,
    input  wire logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0]            start_pt,
    input  wire logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0]            end_pt,
    output logic                                                  q_valid,
    input  wire logic                                             q_ready,
    output logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0]                 q_coord,
    output logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0]                 q_ext,
    output saw_pkg::meta_t                                        q_meta
);

    localparam int SW    = saw_pkg::SHAPE_W;
    localparam int IW    = saw_pkg::IDX_W;
    localparam int NW    = saw_pkg::NDIM_W;
    localparam int CMP_W = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
    localparam logic KIND_BEGIN = 1'b0;

    logic [DIMS-1:0][COORD_BITS-1:0] start_reg, start_next;
    logic [DIMS-1:0][COORD_BITS-1:0] end_reg, end_next;
    logic [DIMS-1:0][COORD_BITS-1:0] cur_reg, cur_next;
    logic [IW-1:0]                   cnt_reg, cnt_next;
    logic                            active_reg, active_next;

    logic                            accept;
    logic                            is_begin;
    logic [DIMS-1:0]                 dim_en;
    logic [DIMS-1:0]                 inc_ok;
    logic [DIMS-1:0][SW-1:0]         ext;
    logic [DIMS-1:0][COORD_BITS-1:0] s_pt, e_pt;
    logic [DIMS-1:0][COORD_BITS-1:0] beg_start, beg_end, beg_cur;
    logic [DIMS-1:0][COORD_BITS-1:0] adv;
    logic [DIMS-1:0][COORD_BITS-1:0] sel_cur, sel_end;
    logic [DIMS-1:0][SW-1:0]         clamp;
    logic                            bad;
    logic                            fin;
    saw_pkg::status_t                st;

    always_comb
    begin
        logic carry;
        accept   = in_valid && q_ready;
        is_begin = (kind == KIND_BEGIN);
        bad      = 1'b0;
        fin      = 1'b1;
        carry    = 1'b1;
        for (int i = 0; i < DIMS; i++)
        begin
            dim_en[i] = (i == 0) || (num_dims > NW'(i));
            ext[i]    = (shape[i] == '0) ? SW'(1) : shape[i];
            s_pt[i]   = COORD_BITS'(start_pt[i]);
            e_pt[i]   = COORD_BITS'(end_pt[i]);
            inc_ok[i] = (CMP_W'(cur_reg[i]) + CMP_W'(1)) < CMP_W'(end_reg[i]);
            if (dim_en[i] && ((CMP_W'(e_pt[i]) > CMP_W'(ext[i]))
                || (CMP_W'(e_pt[i]) <= CMP_W'(s_pt[i]))))
            begin
                bad = 1'b1;
            end
            beg_start[i] = dim_en[i] ? s_pt[i] : start_reg[i];
            beg_end[i]   = dim_en[i] ? e_pt[i] : end_reg[i];
            beg_cur[i]   = dim_en[i] ? s_pt[i] : cur_reg[i];
        end
        // odometer step, innermost dimension first
        for (int j = DIMS - 1; j >= 0; j--)
        begin
            adv[j] = cur_reg[j];
            if (dim_en[j] && carry)
            begin
                if (inc_ok[j])
                begin
                    adv[j] = cur_reg[j] + COORD_BITS'(1);
                    carry  = 1'b0;
                end
                else
                begin
                    adv[j] = start_reg[j];
                end
            end
        end
        sel_cur = is_begin ? beg_cur : adv;
        sel_end = is_begin ? beg_end : end_reg;
        for (int i = 0; i < DIMS; i++)
        begin
            if (dim_en[i] && ((CMP_W'(sel_cur[i]) + CMP_W'(1)) < CMP_W'(sel_end[i])))
            begin
                fin = 1'b0;
            end
            clamp[i] = (CMP_W'(sel_cur[i]) < CMP_W'(ext[i])) ? SW'(sel_cur[i])
                                                              : ext[i] - SW'(1);
        end

        if (is_begin)
        begin
            st = bad ? saw_pkg::ST_BAD_RANGE : saw_pkg::ST_OK;
        end
        else
        begin
            st = active_reg ? saw_pkg::ST_OK : saw_pkg::ST_NO_WALK;
        end

        for (int i = 0; i < DIMS; i++)
        begin
            q_coord[i] = ((st == saw_pkg::ST_OK) && dim_en[i]) ? clamp[i] : '0;
            q_ext[i]   = ((st == saw_pkg::ST_OK) && dim_en[i]) ? ext[i] : SW'(1);
        end
        q_meta.status    = st;
        q_meta.last      = (st == saw_pkg::ST_OK) && fin;
        q_meta.dst_index = ((st == saw_pkg::ST_OK) && !is_begin) ? cnt_reg + IW'(1) : '0;
        q_valid          = in_valid;
        in_ready         = q_ready;

        start_next  = start_reg;
        end_next    = end_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        case (st)
            saw_pkg::ST_OK:
            begin
                active_next = !fin;
                if (is_begin)
                begin
                    start_next = beg_start;
                    end_next   = beg_end;
                    cur_next   = beg_cur;
                    cnt_next   = '0;
                end
                else
                begin
                    cur_next = adv;
                    cnt_next = cnt_reg + IW'(1);
                end
            end
            saw_pkg::ST_BAD_RANGE:
            begin
                active_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            cur_reg    <= '0;
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (accept)
        begin
            start_reg  <= start_next;
            end_reg    <= end_next;
            cur_reg    <= cur_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    a_walk_ends_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(accept))
        else $error("walk went idle without an accepted beat");

    a_idle_next_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_begin && !active_reg |=> $stable(cur_reg) && $stable(cnt_reg))
        else $error("next beat while idle changed the cursor");

endmodule

`default_nettype wire

// ----- rtl/core/saw_queue.sv -----
// two-entry queue between front end and address pipeline
`default_nettype none

module saw_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic [W-1:0]      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// ----- rtl/core/saw_back.sv -----
// back end: pipelined row-major index computation and output register
`default_nettype none

module saw_back #(
    parameter int DIMS = 4
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  q_valid,
    output logic                                       q_ready,
    input  wire logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0] q_coord,
    input  wire logic [DIMS-1:0][saw_pkg::SHAPE_W-1:0] q_ext,
    input  wire saw_pkg::meta_t                        q_meta,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [saw_pkg::IDX_W-1:0]                  src_index,
    output logic [saw_pkg::IDX_W-1:0]                  dst_index,
    output logic                                       last,
    output logic [1:0]                                 status
);

    localparam int SW   = saw_pkg::SHAPE_W;
    localparam int IW   = saw_pkg::IDX_W;
    localparam int HW   = saw_pkg::HALF_W;
    localparam int LO_W = HW + SW;
    localparam int H    = DIMS - 1;
    localparam int NS   = 2 * H + 1;

    logic [NS-1:0]           v_reg;
    logic [IW-1:0]           acc_reg   [NS];
    logic [LO_W-1:0]         plo_reg   [NS];
    logic [HW-1:0]           phi_reg   [NS];
    logic [DIMS-1:0][SW-1:0] coord_reg [NS];
    logic [DIMS-1:0][SW-1:0] ext_reg   [NS];
    saw_pkg::meta_t          meta_reg  [NS];

    logic [IW-1:0]           acc_next  [NS];
    logic [LO_W-1:0]         plo_next  [NS];
    logic [HW-1:0]           phi_next  [NS];
    logic                    en;

    assign en      = !v_reg[NS-1] || out_ready;
    assign q_ready = en;

    // odd stages: partial products of acc * extent, even stages after the load stage 0: sum plus coordinate
    always_comb
    begin
        logic [LO_W-1:0] hi_prod;
        hi_prod = '0;
        for (int k = 0; k < NS; k++)
        begin
            acc_next[k] = '0;
            plo_next[k] = '0;
            phi_next[k] = '0;
        end
        for (int h = 1; h <= H; h++)
        begin
            plo_next[2*h-1] = LO_W'(acc_reg[2*h-2][HW-1:0]) * LO_W'(ext_reg[2*h-2][h]);
            hi_prod         = LO_W'(acc_reg[2*h-2][IW-1:HW]) * LO_W'(ext_reg[2*h-2][h]);
            phi_next[2*h-1] = hi_prod[HW-1:0];
            acc_next[2*h]   = IW'(plo_reg[2*h-1]) + {phi_reg[2*h-1], {HW{1'b0}}}
                              + IW'(coord_reg[2*h-1][h]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg[0] <= q_valid;
            for (int k = 1; k < NS; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg[0]   <= IW'(q_coord[0]);
            coord_reg[0] <= q_coord;
            ext_reg[0]   <= q_ext;
            meta_reg[0]  <= q_meta;
            for (int k = 1; k < NS; k++)
            begin
                coord_reg[k] <= coord_reg[k-1];
                ext_reg[k]   <= ext_reg[k-1];
                meta_reg[k]  <= meta_reg[k-1];
                if (k[0])
                begin
                    plo_reg[k] <= plo_next[k];
                    phi_reg[k] <= phi_next[k];
                end
                else
                begin
                    acc_reg[k] <= acc_next[k];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign src_index = acc_reg[NS-1];
    assign dst_index = meta_reg[NS-1].dst_index;
    assign last      = meta_reg[NS-1].last;
    assign status    = meta_reg[NS-1].status;

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (meta_reg[NS-1].status != saw_pkg::ST_OK)
        |-> (src_index == '0) && !last && (dst_index == '0))
        else $error("error beat carries a nonzero address");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(v_reg))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// ----- bench/tb_subarray_address_walker.sv -----
// testbench for subarray_address_walker: box walks predicted in a scoreboard, checked per beat
`timescale 1ns / 100ps

module tb_subarray_address_walker;

    localparam logic KIND_BEGIN   = 1'b0;
    localparam logic KIND_NEXT    = 1'b1;
    localparam int   RANDOM_ITEMS = 1000;
    localparam int   HOLD_CYCLES  = 24;
    localparam int   STALL_LIMIT  = 4000;

    typedef logic [saw_pkg::PORT_DIMS-1:0][saw_pkg::SHAPE_W-1:0] coord4_t;

    typedef struct {
        logic [saw_pkg::IDX_W-1:0] src;
        logic [saw_pkg::IDX_W-1:0] dst;
        logic                      lst;
        saw_pkg::status_t          st;
    } addr_beat_t;

    class walk_board;
        logic [saw_pkg::NDIM_W-1:0]  ndims;
        logic [saw_pkg::SHAPE_W-1:0] shape [saw_pkg::PORT_DIMS];
        logic [saw_pkg::SHAPE_W-1:0] lo [saw_pkg::PORT_DIMS];
        logic [saw_pkg::SHAPE_W-1:0] hi [saw_pkg::PORT_DIMS];
        logic [saw_pkg::SHAPE_W-1:0] cur [saw_pkg::PORT_DIMS];
        logic [saw_pkg::IDX_W-1:0]   elem_count;
        bit                          walking;
        addr_beat_t                  expected_addrs[$];
        int unsigned                 fails, boxes, boxes_done, bad_ranges, idle_steps;

        function new();
            int i;
            ndims = 1;
            for (i = 0; i < saw_pkg::PORT_DIMS; i++)
            begin
                shape[i] = 1;
                lo[i] = 0;
                hi[i] = 0;
                cur[i] = 0;
            end
            elem_count = 0;
            walking = 0;
            fails = 0;
            boxes = 0;
            boxes_done = 0;
            bad_ranges = 0;
            idle_steps = 0;
        endfunction

        function void set_reg(logic [saw_pkg::REG_IDX_W-1:0] idx,
                              logic [saw_pkg::DATA_W-1:0] value);
            if (idx == saw_pkg::REG_NUM_DIMS)
                ndims = value[saw_pkg::NDIM_W-1:0];
            else
                shape[idx - saw_pkg::REG_SHAPE_0] = value[saw_pkg::SHAPE_W-1:0];
        endfunction

        function int unsigned dims_used();
            int unsigned n;
            n = ndims;
            if (n < 1)
                n = 1;
            if (n > saw_pkg::PORT_DIMS)
                n = saw_pkg::PORT_DIMS;
            return n;
        endfunction

        function int unsigned extent_of(int unsigned i);
            return (shape[i] == 0) ? 1 : shape[i];
        endfunction

        function addr_beat_t element_beat(int unsigned n);
            addr_beat_t                b;
            logic [saw_pkg::IDX_W-1:0] idx;
            int unsigned               e, c, i;
            bit                        fin;
            idx = '0;
            fin = 1;
            for (i = 0; i < n; i++)
            begin
                e = extent_of(i);
                c = (cur[i] < e) ? cur[i] : e - 1;
                idx = idx * e + c;
                if (cur[i] + 1 < hi[i])
                    fin = 0;
            end
            b.src = idx;
            b.dst = elem_count;
            b.lst = fin;
            b.st  = saw_pkg::ST_OK;
            if (fin)
            begin
                walking = 0;
                boxes_done++;
            end
            return b;
        endfunction

        function void predict_step(logic k, coord4_t s, coord4_t e);
            addr_beat_t  b;
            int unsigned n, i;
            int          j;
            bit          bad, stepped;
            n = dims_used();
            b.src = '0;
            b.dst = '0;
            b.lst = 1'b0;
            b.st  = saw_pkg::ST_OK;
            if (k == KIND_BEGIN)
            begin
                bad = 0;
                for (i = 0; i < n; i++)
                    if (e[i] > extent_of(i) || e[i] <= s[i])
                        bad = 1;
                if (bad)
                begin
                    walking = 0;
                    b.st = saw_pkg::ST_BAD_RANGE;
                    bad_ranges++;
                end
                else
                begin
                    for (i = 0; i < n; i++)
                    begin
                        lo[i] = s[i];
                        hi[i] = e[i];
                        cur[i] = s[i];
                    end
                    elem_count = 0;
                    walking = 1;
                    boxes++;
                    b = element_beat(n);
                end
            end
            else if (!walking)
            begin
                b.st = saw_pkg::ST_NO_WALK;
                idle_steps++;
            end
            else
            begin
                // odometer step, last used dimension fastest
                stepped = 0;
                for (j = n - 1; j >= 0 && !stepped; j--)
                begin
                    if (cur[j] + 1 < hi[j])
                    begin
                        cur[j] = cur[j] + 1;
                        stepped = 1;
                    end
                    else
                        cur[j] = lo[j];
                end
                elem_count++;
                b = element_beat(n);
            end
            expected_addrs.push_back(b);
        endfunction

        function void check_beat(logic [saw_pkg::IDX_W-1:0] src,
                                 logic [saw_pkg::IDX_W-1:0] dst, logic lst,
                                 logic [1:0] st);
            addr_beat_t b;
            if (expected_addrs.size() == 0)
            begin
                fails++;
                $display("%0t: output beat with nothing expected: src %h dst %h",
                         $time, src, dst);
                $display("%0t: unexpected beat last %b status %0d", $time, lst, st);
                return;
            end
            b = expected_addrs.pop_front();
            if (src !== b.src)
            begin
                fails++;
                $display("%0t: src_index expected %h actual %h", $time, b.src, src);
            end
            if (dst !== b.dst)
            begin
                fails++;
                $display("%0t: dst_index expected %h actual %h", $time, b.dst, dst);
            end
            if (lst !== b.lst)
            begin
                fails++;
                $display("%0t: last expected %b actual %b", $time, b.lst, lst);
            end
            if (st !== b.st)
            begin
                fails++;
                $display("%0t: status expected %0d actual %0d", $time, b.st, st);
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [saw_pkg::ADDR_W-1:0] paddr = '0;
    logic [saw_pkg::DATA_W-1:0] pwdata = '0;
    logic [saw_pkg::DATA_W-1:0] prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       kind = 1'b0;
    logic [15:0]                start_0 = '0, start_1 = '0, start_2 = '0, start_3 = '0;
    logic [15:0]                end_0 = '0, end_1 = '0, end_2 = '0, end_3 = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [63:0]                src_index, dst_index;
    logic                       last;
    logic [1:0]                 status;

    walk_board   sb;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned reg_writes = 0;
    int unsigned phases = 0;
    int unsigned quiet_cycles = 0;
    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;

    subarray_address_walker dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.predict_step(kind, {start_3, start_2, start_1, start_0},
                                {end_3, end_2, end_1, end_0});
            if (out_valid && out_ready)
                sb.check_beat(src_index, dst_index, last, status);
        end
    end

    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 300 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= rx_tick[2];
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb_subarray_address_walker NOT OK");
            $finish;
        end
    end

    function automatic coord4_t coords(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                       logic [15:0] a3);
        return {a3, a2, a1, a0};
    endfunction

    function automatic coord4_t rand_corner();
        coord4_t c;
        int      i;
        for (i = 0; i < saw_pkg::PORT_DIMS; i++)
            c[i] = saw_pkg::SHAPE_W'($urandom);
        return c;
    endfunction

    task automatic apb_write(logic [saw_pkg::REG_IDX_W-1:0] idx,
                             logic [saw_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
        reg_writes++;
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(logic [saw_pkg::NDIM_W-1:0] nd, coord4_t shp);
        int i;
        apb_write(saw_pkg::REG_NUM_DIMS, saw_pkg::DATA_W'(nd));
        for (i = 0; i < saw_pkg::PORT_DIMS; i++)
            apb_write(saw_pkg::REG_IDX_W'(saw_pkg::REG_SHAPE_0 + i),
                      saw_pkg::DATA_W'(shp[i]));
        apb_idle();
        phases++;
    endtask

    task automatic send_beat(logic k, coord4_t s, coord4_t e);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        kind     <= k;
        start_0  <= s[0];
        start_1  <= s[1];
        start_2  <= s[2];
        start_3  <= s[3];
        end_0    <= e[0];
        end_1    <= e[1];
        end_2    <= e[2];
        end_3    <= e[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic step_next();
        send_beat(KIND_NEXT, rand_corner(), rand_corner());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_addrs.size() != 0)
            @(posedge clk);
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    // legal box of at most three per side, then walked to the end, cut short or overrun
    task automatic walk_box();
        coord4_t     lo, hi;
        int unsigned n, vol, ext, size, steps, i;
        n = sb.dims_used();
        vol = 1;
        lo = rand_corner();
        hi = rand_corner();
        for (i = 0; i < n; i++)
        begin
            ext = sb.extent_of(i);
            size = $urandom_range(1, (ext < 3) ? ext : 3);
            lo[i] = saw_pkg::SHAPE_W'($urandom_range(0, ext - size));
            hi[i] = lo[i] + saw_pkg::SHAPE_W'(size);
            vol *= size;
        end
        send_beat(KIND_BEGIN, lo, hi);
        steps = vol - 1;
        case ($urandom_range(0, 7))
            0: steps = steps / 2;
            1: steps = steps + 1;
            default: ;
        endcase
        repeat (steps) step_next();
    endtask

    task automatic random_config();
        logic [saw_pkg::NDIM_W-1:0] nd;
        coord4_t                    shp;
        int unsigned                r, i;
        r = $urandom_range(0, 15);
        if (r == 0)
            nd = 0;
        else if (r == 1)
            nd = saw_pkg::NDIM_W'($urandom_range(5, 7));
        else
            nd = saw_pkg::NDIM_W'($urandom_range(1, 4));
        for (i = 0; i < saw_pkg::PORT_DIMS; i++)
        begin
            case ($urandom_range(0, 15))
                0: shp[i] = 16'd0;
                1: shp[i] = 16'hffff;
                2: shp[i] = saw_pkg::SHAPE_W'($urandom);
                default: shp[i] = saw_pkg::SHAPE_W'($urandom_range(1, 6));
            endcase
        end
        load_config(nd, shp);
    endtask

    initial
    begin
        int unsigned base, phase_end, pick;
        coord4_t     c;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: one dimension of extent one
        step_next();
        send_beat(KIND_BEGIN, coords(0, 16'hffff, 16'hffff, 16'hffff), coords(1, 0, 0, 0));
        step_next();
        send_beat(KIND_BEGIN, coords(0, 0, 0, 0), coords(0, 0, 0, 0));
        send_beat(KIND_BEGIN, coords(0, 0, 0, 0), coords(2, 0, 0, 0));
        drain();

        load_config(4, coords(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_beat(KIND_BEGIN, coords(16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe),
                  coords(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        send_beat(KIND_BEGIN, coords(1, 2, 0, 16'hfffd), coords(2, 3, 2, 16'hffff));
        repeat (3) step_next();
        step_next();
        send_beat(KIND_BEGIN, coords(0, 0, 0, 5), coords(1, 1, 1, 5));
        send_beat(KIND_BEGIN, coords(0, 0, 0, 0),
                  coords(16'hffff, 16'hffff, 16'hffff, 16'hffff));
        step_next();
        drain();

        // walk still open: fewer dimensions and a zero shape, so the stepped cursor falls outside the extent
        load_config(0, coords(0, 3, 1, 1));
        step_next();
        send_beat(KIND_BEGIN, coords(0, 7, 7, 7), coords(1, 0, 0, 0));
        send_beat(KIND_BEGIN, coords(0, 0, 0, 0), coords(2, 0, 0, 0));
        drain();

        load_config(7, coords(2, 3, 2, 2));
        send_beat(KIND_BEGIN, coords(0, 0, 0, 0), coords(2, 3, 2, 2));
        repeat (3) step_next();
        drain();
        apb_write(saw_pkg::REG_IDX_W'(saw_pkg::REG_SHAPE_0 + 1), 32'd1);
        apb_idle();
        repeat (3) step_next();
        drain();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            random_config();
            phase_end = items_sent + $urandom_range(40, 120);
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    walk_box();
                else if (pick == 7)
                    send_beat(KIND_BEGIN, rand_corner(), rand_corner());
                else if (pick == 8)
                begin
                    c = rand_corner();
                    send_beat(KIND_BEGIN, c, c);
                end
                else
                    step_next();
            end
            drain();
        end

        $display("run covered %0d input beats: %0d boxes begun, %0d walked to the end,",
                 items_sent, sb.boxes, sb.boxes_done);
        $display("%0d bad ranges, %0d idle steps, %0d register writes over %0d configurations",
                 sb.bad_ranges, sb.idle_steps, reg_writes, phases);
        if (sb.fails == 0 && sb.expected_addrs.size() == 0)
            $display("tb_subarray_address_walker OK");
        else
            $display("tb_subarray_address_walker NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/saw_pkg.sv
rtl/core/saw_front.sv
rtl/core/saw_queue.sv
rtl/core/saw_back.sv
rtl/core/subarray_address_walker.sv
bench/tb_subarray_address_walker.sv
